[src/lora_pkg.sv]
// ----------------------------------------------------------------------------
// lora_pkg
// Shared types and constants for the low-rank adapted linear layer.
// ----------------------------------------------------------------------------
`default_nettype none

package lora_pkg;

	localparam int IN_DIM_DEF   = 16;
	localparam int OUT_DIM_DEF  = 16;
	localparam int MAX_RANK_DEF = 4;
	localparam int MAX_EMIT     = 16;

	localparam int VALW  = 16;
	localparam int IDXW  = 6;   // widest counter the parameter ranges need
	localparam int RNKW  = 4;
	localparam int ACCW  = 64;
	localparam int RPW   = 40;
	localparam int CFGAW = 2;

	localparam logic [2:0] OP_LOAD_W    = 3'd0;
	localparam logic [2:0] OP_LOAD_A    = 3'd1;
	localparam logic [2:0] OP_LOAD_B    = 3'd2;
	localparam logic [2:0] OP_LOAD_BIAS = 3'd3;
	localparam logic [2:0] OP_X         = 3'd4;

	localparam logic [CFGAW-1:0] REG_IN_DIM  = 2'd0;
	localparam logic [CFGAW-1:0] REG_OUT_DIM = 2'd1;
	localparam logic [CFGAW-1:0] REG_RANK    = 2'd2;
	localparam logic [CFGAW-1:0] REG_SCALE   = 2'd3;

	typedef enum logic [2:0] {
		SRC_AX     = 3'd0,
		SRC_BRP_LO = 3'd1,
		SRC_BRP_HI = 3'd2,
		SRC_WX     = 3'd3,
		SRC_BIAS   = 3'd4,
		SRC_SC_LO  = 3'd5,
		SRC_SC_HI  = 3'd6
	} mac_src_t;

	typedef struct packed {
		logic            in_ready;
		logic [IDXW-1:0] c_idx;
		logic [RNKW-1:0] r_idx;
		logic [IDXW-1:0] o_idx;
		mac_src_t        src;
		logic            mac_en;
		logic            clr;
		logic            store_rp;
		logic            load_lora;
		logic            emit;
		logic            last_out;
	} lora_cmd_t;

	typedef struct packed {
		logic            start;
		logic            out_free;
		logic [IDXW-1:0] nin_m1;
		logic [IDXW-1:0] nout_m1;
		logic [RNKW-1:0] nrank_m1;
	} lora_sts_t;

endpackage

`default_nettype wire

[src/lora_in_if.sv]
// ----------------------------------------------------------------------------
// lora_in_if
// Input item channel: loads and x elements.
// ----------------------------------------------------------------------------
`default_nettype none

interface lora_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic [3:0]        row_index;
	logic [3:0]        col_index;
	logic signed [15:0] value;
	logic              last_element;

	modport source (output valid, opcode, row_index, col_index, value, last_element,
		input ready);
	modport sink (input valid, opcode, row_index, col_index, value, last_element,
		output ready);
endinterface

`default_nettype wire

[src/lora_out_if.sv]
// ----------------------------------------------------------------------------
// lora_out_if
// Result item channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lora_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_index;
	logic signed [15:0] out_value;
	logic               saturated;
	logic               last_output;

	modport source (output valid, out_index, out_value, saturated, last_output,
		input ready);
	modport sink (input valid, out_index, out_value, saturated, last_output,
		output ready);
endinterface

`default_nettype wire

[src/lora_cfg_if.sv]
// ----------------------------------------------------------------------------
// lora_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lora_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/lora_ram.sv]
// ----------------------------------------------------------------------------
// lora_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lora_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/lora_ctrl.sv]
// ----------------------------------------------------------------------------
// lora_ctrl
// Sequencer stepping the shared multiply-accumulate through a vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lora_ctrl #(
	parameter int IN_DIM   = lora_pkg::IN_DIM_DEF,
	parameter int OUT_DIM  = lora_pkg::OUT_DIM_DEF,
	parameter int MAX_RANK = lora_pkg::MAX_RANK_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lora_pkg::lora_sts_t sts,
	output lora_pkg::lora_cmd_t      cmd
);

	localparam int CW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
	localparam int OW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
	localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_RP_RD  = 14'b00000000000010,
		ST_RP_MAC = 14'b00000000000100,
		ST_LB_RD  = 14'b00000000001000,
		ST_LB_LO  = 14'b00000000010000,
		ST_LB_HI  = 14'b00000000100000,
		ST_W_RD   = 14'b00000001000000,
		ST_W_MAC  = 14'b00000010000000,
		ST_BIAS   = 14'b00000100000000,
		ST_SC_LO  = 14'b00001000000000,
		ST_SC_HI  = 14'b00010000000000,
		ST_OUT    = 14'b00100000000000,
		ST_SPARE1 = 14'b01000000000000,
		ST_SPARE2 = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] c_q, c_d;
	logic [RW-1:0] r_q, r_d;
	logic [OW-1:0] o_q, o_d;
	logic c_last, r_last, o_last;

	assign c_last = (c_q == sts.nin_m1[CW-1:0]);
	assign r_last = (r_q == sts.nrank_m1[RW-1:0]);
	assign o_last = (o_q == sts.nout_m1[OW-1:0]);

	always_comb begin
		state_d      = state_q;
		c_d          = c_q;
		r_d          = r_q;
		o_d          = o_q;
		cmd          = '0;
		cmd.c_idx    = lora_pkg::IDXW'(c_q);
		cmd.r_idx    = lora_pkg::RNKW'(r_q);
		cmd.o_idx    = lora_pkg::IDXW'(o_q);
		cmd.src      = lora_pkg::SRC_AX;
		cmd.last_out = o_last;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.start) begin
					c_d     = '0;
					r_d     = '0;
					o_d     = '0;
					state_d = ST_RP_RD;
				end
			end
			ST_RP_RD: state_d = ST_RP_MAC;
			ST_RP_MAC: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_AX;
				cmd.clr    = (c_q == '0);
				if (c_last) begin
					cmd.store_rp = 1'b1;
					c_d          = '0;
					if (r_last) begin
						r_d     = '0;
						state_d = ST_LB_RD;
					end else begin
						r_d     = r_q + 1'b1;
						state_d = ST_RP_RD;
					end
				end else begin
					c_d     = c_q + 1'b1;
					state_d = ST_RP_RD;
				end
			end
			ST_LB_RD: state_d = ST_LB_LO;
			ST_LB_LO: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_BRP_LO;
				cmd.clr    = (r_q == '0);
				state_d    = ST_LB_HI;
			end
			ST_LB_HI: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_BRP_HI;
				if (r_last) begin
					cmd.load_lora = 1'b1;
					r_d           = '0;
					c_d           = '0;
					state_d       = ST_W_RD;
				end else begin
					r_d     = r_q + 1'b1;
					state_d = ST_LB_RD;
				end
			end
			ST_W_RD: state_d = ST_W_MAC;
			ST_W_MAC: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_WX;
				cmd.clr    = (c_q == '0);
				if (c_last) begin
					c_d     = '0;
					state_d = ST_BIAS;
				end else begin
					c_d     = c_q + 1'b1;
					state_d = ST_W_RD;
				end
			end
			ST_BIAS: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_BIAS;
				state_d    = ST_SC_LO;
			end
			ST_SC_LO: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_SC_LO;
				state_d    = ST_SC_HI;
			end
			ST_SC_HI: begin
				cmd.mac_en = 1'b1;
				cmd.src    = lora_pkg::SRC_SC_HI;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (o_last) begin
						state_d = ST_IDLE;
					end else begin
						o_d     = o_q + 1'b1;
						state_d = ST_LB_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			r_q     <= '0;
			o_q     <= '0;
		end else begin
			state_q <= state_d;
			c_q     <= c_d;
			r_q     <= r_d;
			o_q     <= o_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted into a full output register");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.start && state_q != ST_IDLE) |=> $stable(o_q))
		else $error("start seen while busy disturbed the sequence");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last_out) |=> state_q == ST_IDLE)
		else $error("final result did not return the sequencer to idle");
	a_o_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (o_q <= sts.nout_m1[OW-1:0]))
		else $error("output index beyond the configured count");
`endif

endmodule

`default_nettype wire

[src/lora_dp.sv]
// ----------------------------------------------------------------------------
// lora_dp
// Stores, configuration registers, shared multiply-accumulate and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lora_dp #(
	parameter int IN_DIM   = lora_pkg::IN_DIM_DEF,
	parameter int OUT_DIM  = lora_pkg::OUT_DIM_DEF,
	parameter int MAX_RANK = lora_pkg::MAX_RANK_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	lora_in_if.sink                  in_ch,
	lora_out_if.source               out_ch,
	lora_cfg_if.sink                 cfg,
	input  wire lora_pkg::lora_cmd_t cmd,
	output lora_pkg::lora_sts_t      sts
);

	localparam int CW  = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
	localparam int OW  = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
	localparam int RW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int WD  = OUT_DIM * IN_DIM;
	localparam int AD  = MAX_RANK * IN_DIM;
	localparam int BD  = OUT_DIM * MAX_RANK;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam int AAW = (AD > 1) ? $clog2(AD) : 1;
	localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
	localparam int MAX_OUT = (OUT_DIM < lora_pkg::MAX_EMIT) ? OUT_DIM : lora_pkg::MAX_EMIT;
	localparam int ACCW = lora_pkg::ACCW;
	localparam int RPW  = lora_pkg::RPW;

	// configuration
	logic [4:0]  in_dim_q, out_dim_q;
	logic [2:0]  rank_q;
	logic [15:0] scale_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_dim_q  <= 5'd16;
			out_dim_q <= 5'd16;
			rank_q    <= 3'd4;
			scale_q   <= 16'd256;
		end else if (cfg.valid) begin
			case (cfg.index)
				lora_pkg::REG_IN_DIM:  in_dim_q  <= cfg.data[4:0];
				lora_pkg::REG_OUT_DIM: out_dim_q <= cfg.data[4:0];
				lora_pkg::REG_RANK:    rank_q    <= cfg.data[2:0];
				lora_pkg::REG_SCALE:   scale_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamped counts, held as count minus one
	always_comb begin
		sts.nin_m1   = (in_dim_q == '0) ? '0 :
			(int'(in_dim_q) > IN_DIM) ? lora_pkg::IDXW'(IN_DIM - 1) :
			lora_pkg::IDXW'(in_dim_q - 5'd1);
		sts.nout_m1  = (out_dim_q == '0) ? '0 :
			(int'(out_dim_q) > MAX_OUT) ? lora_pkg::IDXW'(MAX_OUT - 1) :
			lora_pkg::IDXW'(out_dim_q - 5'd1);
		sts.nrank_m1 = (rank_q == '0) ? '0 :
			(int'(rank_q) > MAX_RANK) ? lora_pkg::RNKW'(MAX_RANK - 1) :
			lora_pkg::RNKW'(rank_q - 3'd1);
	end

	// input item decode
	logic acc_in, row_ok_out, row_ok_rank, col_ok_in, col_ok_rank;
	logic we_w, we_a, we_b;

	assign acc_in      = in_ch.valid && cmd.in_ready;
	assign in_ch.ready = cmd.in_ready;
	assign row_ok_out  = int'(in_ch.row_index) < OUT_DIM;
	assign row_ok_rank = int'(in_ch.row_index) < MAX_RANK;
	assign col_ok_in   = int'(in_ch.col_index) < IN_DIM;
	assign col_ok_rank = int'(in_ch.col_index) < MAX_RANK;
	assign we_w = acc_in && in_ch.opcode == lora_pkg::OP_LOAD_W && row_ok_out && col_ok_in;
	assign we_a = acc_in && in_ch.opcode == lora_pkg::OP_LOAD_A && row_ok_rank && col_ok_in;
	assign we_b = acc_in && in_ch.opcode == lora_pkg::OP_LOAD_B && row_ok_out && col_ok_rank;
	assign sts.start = acc_in && in_ch.opcode == lora_pkg::OP_X && in_ch.last_element;

	logic [WAW-1:0] w_waddr, w_raddr;
	logic [AAW-1:0] a_waddr, a_raddr;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [15:0]    w_rd, a_rd, b_rd;

	assign w_waddr = WAW'(int'(in_ch.row_index) * IN_DIM + int'(in_ch.col_index));
	assign a_waddr = AAW'(int'(in_ch.row_index) * IN_DIM + int'(in_ch.col_index));
	assign b_waddr = BAW'(int'(in_ch.row_index) * MAX_RANK + int'(in_ch.col_index));
	assign w_raddr = WAW'(int'(cmd.o_idx[OW-1:0]) * IN_DIM + int'(cmd.c_idx[CW-1:0]));
	assign a_raddr = AAW'(int'(cmd.r_idx[RW-1:0]) * IN_DIM + int'(cmd.c_idx[CW-1:0]));
	assign b_raddr = BAW'(int'(cmd.o_idx[OW-1:0]) * MAX_RANK + int'(cmd.r_idx[RW-1:0]));

	lora_ram #(.WIDTH(16), .DEPTH(WD)) u_w_ram (
		.clk(clk), .we(we_w), .waddr(w_waddr), .wdata(in_ch.value),
		.raddr(w_raddr), .rdata(w_rd));
	lora_ram #(.WIDTH(16), .DEPTH(AD)) u_a_ram (
		.clk(clk), .we(we_a), .waddr(a_waddr), .wdata(in_ch.value),
		.raddr(a_raddr), .rdata(a_rd));
	lora_ram #(.WIDTH(16), .DEPTH(BD)) u_b_ram (
		.clk(clk), .we(we_b), .waddr(b_waddr), .wdata(in_ch.value),
		.raddr(b_raddr), .rdata(b_rd));

	// up projection resets to zero: per-entry valid bits
	logic [BD-1:0] b_vld_q;
	logic          b_vld_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_q    <= '0;
			b_vld_rd_q <= 1'b0;
		end else begin
			if (we_b) begin
				b_vld_q[b_waddr] <= 1'b1;
			end
			b_vld_rd_q <= b_vld_q[b_raddr];
		end
	end

	// x vector, bias and rank products in flops
	logic signed [15:0]    x_q    [IN_DIM];
	logic signed [15:0]    bias_q [OUT_DIM];
	logic signed [RPW-1:0] rp_q   [MAX_RANK];
	logic signed [RPW-1:0] lora8_q;
	logic signed [ACCW-1:0] acc_q, acc_d, lr_full;

	always_ff @(posedge clk) begin
		if (acc_in && in_ch.opcode == lora_pkg::OP_X && col_ok_in) begin
			x_q[in_ch.col_index[CW-1:0]] <= in_ch.value;
		end
		if (cmd.load_lora) begin
			lora8_q <= lr_full[RPW+15:16];
		end
		if (cmd.mac_en) begin
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OUT_DIM; i++) begin
				bias_q[i] <= '0;
			end
			for (int i = 0; i < MAX_RANK; i++) begin
				rp_q[i] <= '0;
			end
		end else begin
			if (acc_in && in_ch.opcode == lora_pkg::OP_LOAD_BIAS && row_ok_out) begin
				bias_q[in_ch.row_index[OW-1:0]] <= in_ch.value;
			end
			if (cmd.store_rp) begin
				rp_q[cmd.r_idx[RW-1:0]] <= acc_d[RPW-1:0];
			end
		end
	end

	// shared multiply-accumulate, 17 x 21 signed, wide operands split at bit 20
	logic signed [16:0]     op_a;
	logic signed [20:0]     op_b;
	logic signed [37:0]     prod;
	logic signed [ACCW-1:0] prod_ext;
	logic                   hi_part;
	logic signed [RPW-1:0]  rp_sel;
	logic signed [15:0]     b_eff;

	assign rp_sel = rp_q[cmd.r_idx[RW-1:0]];
	assign b_eff  = b_vld_rd_q ? signed'(b_rd) : 16'sd0;

	always_comb begin
		op_a    = 17'sd0;
		op_b    = 21'sd0;
		hi_part = 1'b0;
		case (cmd.src)
			lora_pkg::SRC_AX: begin
				op_a = 17'(signed'(a_rd));
				op_b = 21'(x_q[cmd.c_idx[CW-1:0]]);
			end
			lora_pkg::SRC_BRP_LO: begin
				op_a = 17'(b_eff);
				op_b = signed'({1'b0, rp_sel[19:0]});
			end
			lora_pkg::SRC_BRP_HI: begin
				op_a    = 17'(b_eff);
				op_b    = 21'(signed'(rp_sel[RPW-1:20]));
				hi_part = 1'b1;
			end
			lora_pkg::SRC_WX: begin
				op_a = 17'(signed'(w_rd));
				op_b = 21'(x_q[cmd.c_idx[CW-1:0]]);
			end
			lora_pkg::SRC_BIAS: begin
				op_a = 17'(bias_q[cmd.o_idx[OW-1:0]]);
				op_b = 21'sd256;
			end
			lora_pkg::SRC_SC_LO: begin
				op_a = signed'({1'b0, scale_q});
				op_b = signed'({1'b0, lora8_q[19:0]});
			end
			lora_pkg::SRC_SC_HI: begin
				op_a    = signed'({1'b0, scale_q});
				op_b    = 21'(signed'(lora8_q[RPW-1:20]));
				hi_part = 1'b1;
			end
			default: ;
		endcase
	end

	assign prod     = op_a * op_b;
	assign prod_ext = hi_part ? (ACCW'(prod) <<< 20) : ACCW'(prod);
	assign acc_d    = (cmd.clr ? '0 : acc_q) + prod_ext;
	// round half up then floor by 2^16
	assign lr_full  = acc_d + 64'sd32768;

	// rounding, saturation and result register
	logic signed [ACCW-1:0] y_full;
	logic signed [ACCW-9:0] y_sh;
	logic                   sat_hi, sat_lo;
	logic                   out_valid_q;
	logic [3:0]             out_index_q;
	logic signed [15:0]     out_value_q;
	logic                   sat_q, last_q;

	assign y_full = acc_q + 64'sd128;
	assign y_sh   = y_full[ACCW-1:8];
	assign sat_hi = y_sh > 56'sd32767;
	assign sat_lo = y_sh < -56'sd32768;

	assign sts.out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= 4'(cmd.o_idx[OW-1:0]);
			out_value_q <= sat_hi ? 16'sd32767 : sat_lo ? -16'sd32768 : y_sh[15:0];
			sat_q       <= sat_hi || sat_lo;
			last_q      <= cmd.last_out;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_index   = out_index_q;
	assign out_ch.out_value   = out_value_q;
	assign out_ch.saturated   = sat_q;
	assign out_ch.last_output = last_q;

endmodule

`default_nettype wire

[src/low_rank_adapted_linear_layer_top.sv]
// ----------------------------------------------------------------------------
// low_rank_adapted_linear_layer_top
// Linear layer with low-rank adapter: y = W*x + scale*(B*(A*x)) + bias, Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries load items (W, A, B, bias entries) and x elements. Loads and
//  x elements are taken one a cycle while the block is idle. The x element
//  marked last starts a vector; in_ch.ready then stays low until the final
//  result of that vector has been placed in the output register.
//  With n = in_dim_used, m = out_dim_used and k = rank_used, the time a vector
//  takes is set by the single shared multiply-accumulate and the registered
//  read of the coefficient RAMs (a read state before each product, and a
//  low and a high half for each wide adapter product).
//  out_ch emits m results in index order, last_output on the final one.
//  If out_ch.ready is held low the sequencer waits with a finished result in
//  the output register; nothing is dropped.
//  cfg is always ready; write it only while idle.
//  Reset clears control, registers to their defaults, bias and up projection
//  to zero; W, A and x hold unknown values until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module low_rank_adapted_linear_layer_top #(
	parameter int IN_DIM   = lora_pkg::IN_DIM_DEF,
	parameter int OUT_DIM  = lora_pkg::OUT_DIM_DEF,
	parameter int MAX_RANK = lora_pkg::MAX_RANK_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lora_in_if.sink    in_ch,
	lora_out_if.source out_ch,
	lora_cfg_if.sink   cfg
);

	lora_pkg::lora_cmd_t cmd;
	lora_pkg::lora_sts_t sts;

	lora_ctrl #(.IN_DIM(IN_DIM), .OUT_DIM(OUT_DIM), .MAX_RANK(MAX_RANK)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd));

	lora_dp #(.IN_DIM(IN_DIM), .OUT_DIM(OUT_DIM), .MAX_RANK(MAX_RANK)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.cmd(cmd), .sts(sts));

endmodule

`default_nettype wire

[tb/low_rank_adapted_linear_layer_top_tb.sv]
// ----------------------------------------------------------------------------
// low_rank_adapted_linear_layer_top_tb
// Loads the weight, adapter and bias stores and feeds x vectors to the block
// under several register settings, predicts every output element in Q8.8
// and checks index, value, saturation flag and last marker in order.
// ----------------------------------------------------------------------------
`default_nettype none

module low_rank_adapted_linear_layer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [3:0]         row_index;
		logic [3:0]         col_index;
		logic signed [15:0] value;
		logic               last_element;
	} load_item_t;

	typedef struct packed {
		logic [3:0]         out_index;
		logic signed [15:0] out_value;
		logic               saturated;
		logic               last_output;
	} out_elem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lora_in_if  in_ch();
	lora_out_if out_ch();
	lora_cfg_if cfg();

	low_rank_adapted_linear_layer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's stores and registers
	logic signed [15:0] w_mem [16][16];
	logic signed [15:0] a_mem [4][16];
	logic signed [15:0] b_mem [16][4];
	logic signed [15:0] bias_mem [16];
	logic signed [15:0] x_vec [16];
	logic [4:0]  n_in_reg, n_out_reg;
	logic [2:0]  rank_reg;
	logic [15:0] scale_reg;

	load_item_t pending_items[$];
	out_elem_t  expected_outputs[$];
	int errors = 0;
	int hold_off = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint floor_div(input longint v, input int s);
		return v >>> s;
	endfunction

	task automatic compute_column();
		int unsigned ni, no, nr;
		longint rp [4];
		longint lora, acc, y;
		ni = clamp_reg(n_in_reg, 16);
		no = clamp_reg(n_out_reg, 16);
		nr = clamp_reg(rank_reg, 4);
		for (int r = 0; r < nr; r++) begin
			rp[r] = 0;
			for (int c = 0; c < ni; c++)
				rp[r] += longint'(a_mem[r][c]) * longint'(x_vec[c]);
		end
		for (int o = 0; o < no; o++) begin
			out_elem_t e;
			lora = 0;
			acc = 0;
			for (int r = 0; r < nr; r++)
				lora += longint'(b_mem[o][r]) * rp[r];
			lora = floor_div(lora + (64'sd1 <<< 15), 16);
			for (int c = 0; c < ni; c++)
				acc += longint'(w_mem[o][c]) * longint'(x_vec[c]);
			acc += longint'(bias_mem[o]) * 256;
			acc += lora * longint'({1'b0, scale_reg});
			y = floor_div(acc + 128, 8);
			e.saturated = 1'b0;
			if (y > 32767) begin
				y = 32767;
				e.saturated = 1'b1;
			end
			if (y < -32768) begin
				y = -32768;
				e.saturated = 1'b1;
			end
			e.out_index = o[3:0];
			e.out_value = y[15:0];
			e.last_output = (o + 1 == no);
			expected_outputs.push_back(e);
		end
	endtask

	task automatic apply_item(input load_item_t it);
		case (it.opcode)
			lora_pkg::OP_LOAD_W: w_mem[it.row_index][it.col_index] = it.value;
			lora_pkg::OP_LOAD_A:
				if (it.row_index < 4) a_mem[it.row_index][it.col_index] = it.value;
			lora_pkg::OP_LOAD_B:
				if (it.col_index < 4) b_mem[it.row_index][it.col_index] = it.value;
			lora_pkg::OP_LOAD_BIAS: bias_mem[it.row_index] = it.value;
			lora_pkg::OP_X: begin
				x_vec[it.col_index] = it.value;
				if (it.last_element)
					compute_column();
			end
			default: ;
		endcase
	endtask

	// driver
	int in_gap = 0;
	bit in_taken = 1'b0;
	always @(negedge clk) begin
		if (!in_ch.valid || in_taken) begin
			in_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0 && arst_n) begin
				load_item_t it;
				it = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.opcode <= it.opcode;
				in_ch.row_index <= it.row_index;
				in_ch.col_index <= it.col_index;
				in_ch.value <= it.value;
				in_ch.last_element <= it.last_element;
				in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				if ($urandom_range(0, 4) == 0)
					in_gap = 0;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	load_item_t in_now;
	assign in_now = '{in_ch.opcode, in_ch.row_index, in_ch.col_index, in_ch.value,
		in_ch.last_element};

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			apply_item(in_now);
			in_taken = 1'b1;
		end
	end

	// receiver stalls
	int out_gap = 0;
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (out_ch.ready && out_ch.valid)
				out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_outputs.size() == 0) begin
				report("unexpected output index", out_ch.out_index, -1);
			end else begin
				out_elem_t e;
				e = expected_outputs.pop_front();
				if (out_ch.out_index !== e.out_index)
					report("out_index", out_ch.out_index, e.out_index);
				if (out_ch.out_value !== e.out_value)
					report("out_value", out_ch.out_value, e.out_value);
				if (out_ch.saturated !== e.saturated)
					report("saturated", out_ch.saturated, e.saturated);
				if (out_ch.last_output !== e.last_output)
					report("last_output", out_ch.last_output, e.last_output);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			lora_pkg::REG_IN_DIM:  n_in_reg = d[4:0];
			lora_pkg::REG_OUT_DIM: n_out_reg = d[4:0];
			lora_pkg::REG_RANK:    rank_reg = d[2:0];
			default:               scale_reg = d;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic load_item_t mk(input logic [2:0] op, input int r, input int c,
			input logic signed [15:0] v, input logic l);
		load_item_t it;
		it.opcode = op;
		it.row_index = r[3:0];
		it.col_index = c[3:0];
		it.value = v;
		it.last_element = l;
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || expected_outputs.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// full W and A store load with random content, then an x vector
	task automatic queue_full_load(input bit small_vals);
		for (int o = 0; o < 16; o++)
			for (int c = 0; c < 16; c++)
				pending_items.push_back(mk(lora_pkg::OP_LOAD_W, o, c,
					small_vals ? 16'(signed'($urandom_range(0, 511)) - 256) : rand_value(),
					1'($urandom)));
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 16; c++)
				pending_items.push_back(mk(lora_pkg::OP_LOAD_A, r, c, rand_value(), 1'b0));
		for (int x = 0; x < 16; x++)
			pending_items.push_back(mk(lora_pkg::OP_X, $urandom_range(0, 15), x,
				rand_value(), 1'b0));
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			int k;
			k = $urandom_range(0, 19);
			if (k < 6)
				pending_items.push_back(mk(lora_pkg::OP_X, $urandom_range(0, 15),
					$urandom_range(0, 15), rand_value(), 1'b0));
			else if (k < 9)
				pending_items.push_back(mk(lora_pkg::OP_X, $urandom_range(0, 15),
					$urandom_range(0, 15), rand_value(), 1'b1));
			else if (k < 11)
				pending_items.push_back(mk(lora_pkg::OP_LOAD_W, $urandom_range(0, 15),
					$urandom_range(0, 15), rand_value(), 1'($urandom)));
			else if (k < 13)
				pending_items.push_back(mk(lora_pkg::OP_LOAD_A, $urandom_range(0, 7),
					$urandom_range(0, 15), rand_value(), 1'($urandom)));
			else if (k < 16)
				pending_items.push_back(mk(lora_pkg::OP_LOAD_B, $urandom_range(0, 15),
					$urandom_range(0, 7), rand_value(), 1'($urandom)));
			else if (k < 18)
				pending_items.push_back(mk(lora_pkg::OP_LOAD_BIAS, $urandom_range(0, 15),
					$urandom_range(0, 15), rand_value(), 1'($urandom)));
			else
				pending_items.push_back(mk(3'($urandom_range(5, 7)), $urandom_range(0, 15),
					$urandom_range(0, 15), rand_value(), 1'($urandom)));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = lora_pkg::OP_LOAD_W;
		in_ch.row_index = '0;
		in_ch.col_index = '0;
		in_ch.value = '0;
		in_ch.last_element = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = lora_pkg::REG_IN_DIM;
		cfg.data = '0;
		n_in_reg = 16;
		n_out_reg = 16;
		rank_reg = 4;
		scale_reg = 256;
		for (int o = 0; o < 16; o++) begin
			bias_mem[o] = '0;
			for (int r = 0; r < 4; r++)
				b_mem[o][r] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill stores, then extremes and special cases
		queue_full_load(1'b0);
		pending_items.push_back(mk(lora_pkg::OP_LOAD_B, 0, 0, 16'sh7fff, 1'b1));
		pending_items.push_back(mk(lora_pkg::OP_LOAD_B, 15, 3, 16'sh8000, 1'b0));
		// column out of range
		pending_items.push_back(mk(lora_pkg::OP_LOAD_B, 2, 9, 16'sh1234, 1'b0));
		// row out of range
		pending_items.push_back(mk(lora_pkg::OP_LOAD_A, 9, 1, 16'sh1234, 1'b0));
		pending_items.push_back(mk(lora_pkg::OP_LOAD_BIAS, 15, 7, 16'sh7fff, 1'b1));
		pending_items.push_back(mk(lora_pkg::OP_LOAD_BIAS, 0, 0, 16'sh8000, 1'b0));
		pending_items.push_back(mk(3'd5, 3, 3, 16'sh5555, 1'b1));
		pending_items.push_back(mk(3'd7, 15, 15, 16'shaaaa, 1'b1));
		pending_items.push_back(mk(lora_pkg::OP_X, 15, 15, 16'sh7fff, 1'b1));
		pending_items.push_back(mk(lora_pkg::OP_X, 0, 0, 16'sh8000, 1'b1));
		wait_drained();

		// long receiver hold-off while the sender keeps going
		hold_off = 400;
		pending_items.push_back(mk(lora_pkg::OP_X, 0, 3, 16'sh0100, 1'b1));
		pending_items.push_back(mk(lora_pkg::OP_X, 0, 4, 16'sh0200, 1'b1));
		pending_items.push_back(mk(lora_pkg::OP_LOAD_BIAS, 1, 0, 16'sh0080, 1'b0));
		wait_drained();

		// extremes of the registers, including values that get clamped
		write_reg(lora_pkg::REG_IN_DIM, 16'd1);
		write_reg(lora_pkg::REG_OUT_DIM, 16'd1);
		write_reg(lora_pkg::REG_RANK, 16'd1);
		write_reg(lora_pkg::REG_SCALE, 16'hffff);
		queue_random(30);
		wait_drained();
		write_reg(lora_pkg::REG_IN_DIM, 16'd0);
		write_reg(lora_pkg::REG_OUT_DIM, 16'd31);
		write_reg(lora_pkg::REG_RANK, 16'd7);
		write_reg(lora_pkg::REG_SCALE, 16'd0);
		queue_random(30);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(lora_pkg::REG_IN_DIM, 16'($urandom_range(1, 16)));
			write_reg(lora_pkg::REG_OUT_DIM, 16'($urandom_range(1, 16)));
			write_reg(lora_pkg::REG_RANK, 16'($urandom_range(1, 4)));
			write_reg(lora_pkg::REG_SCALE, 16'($urandom));
			queue_random(15);
			wait_drained();
		end

		write_reg(lora_pkg::REG_IN_DIM, 16'd16);
		write_reg(lora_pkg::REG_OUT_DIM, 16'd16);
		write_reg(lora_pkg::REG_RANK, 16'd4);
		write_reg(lora_pkg::REG_SCALE, 16'd256);
		queue_random(30);
		wait_drained();

		if (errors == 0)
			$display("low_rank_adapted_linear_layer_top_tb passed");
		else
			$display("low_rank_adapted_linear_layer_top_tb failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("low_rank_adapted_linear_layer_top_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
